FILE: src/hwpid_pkg.sv
// Shared types, widths, reset values and register indexes of the heater warm-up PID controller.
`timescale 1ns / 1ps
`default_nettype none

package hwpid_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_INT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_OUT_LIMIT   = 3'd4;
    localparam logic [2:0] REG_PWM_FS      = 3'd5;
    localparam logic [2:0] REG_TARGET      = 3'd6;
    localparam logic [2:0] REG_MAX_TARGET  = 3'd7;

    // Register reset values.
    localparam logic [31:0] RST_GAIN_P     = 32'd104857600;
    localparam logic [31:0] RST_GAIN_I     = 32'd13107;
    localparam logic [31:0] RST_GAIN_D     = 32'd0;
    localparam logic [15:0] RST_INT_LIMIT  = 16'd4400;
    localparam logic [15:0] RST_OUT_LIMIT  = 16'd4500;
    localparam logic [15:0] RST_PWM_FS     = 16'd5000;
    localparam logic [7:0]  RST_TARGET     = 8'd0;
    localparam logic [7:0]  RST_MAX_TARGET = 8'd45;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    // Datapath widths.
    localparam int ERR_W    = 18;  // Q10.8 error
    localparam int DERR_W   = 19;  // error change
    localparam int PPROD_W  = 51;  // gain times error, Q27.24
    localparam int DPROD_W  = 52;  // gain times error change
    localparam int PTERM_W  = 43;  // term in counts with 16 fraction bits
    localparam int DTERM_W  = 44;
    localparam int PD_W     = 45;  // proportional plus derivative
    localparam int ACC_W    = 33;  // clamped integral
    localparam int ACCSUM_W = 44;  // integral before clamping
    localparam int SUM_W    = 46;  // PID sum before clamping

    typedef enum logic [2:0] {
        MODE_WARM   = 3'b001,
        MODE_SWITCH = 3'b010,
        MODE_REG    = 3'b100
    } mode_t;

endpackage

`default_nettype wire

FILE: src/heater_warmup_pid_controller_unit.sv
// Top level of the heater warm-up PID controller: four-stage pipelined datapath.
`timescale 1ns / 1ps
`default_nettype none

// Heater warm-up and PID controller.
// The slave stream takes one temperature sample per word (tdata[15:0], signed
// Q8.8 degrees). The master stream returns one word per sample: the heater PWM
// compare value, the sticky reached flag and the warm-up flag.
// The configuration channel writes one register per handshake; cfg_ready is
// always high. The user must see that registers are changed only while no
// sample is in flight; the block does not enforce it. An accepted sample goes
// through error and mode, gain multiplies, integral update and output clamp
// to its result word. Throughput is one sample per cycle unless the receiver
// stalls; the integral accumulator, adding and clamping per sample, bounds it.
// Each stage moves on when the stage after it is empty or moving, so a stalled
// receiver holds the result word and the stages behind it keep filling until
// all are full; only then does s_tready drop.
// Reset clears the pipeline, returns to warm-up with a zero integral, zero
// held PWM and a clear reached flag, and loads the register reset values.
module heater_warmup_pid_controller_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata fields from bit 0: measured_temp[15:0]
    input  wire logic [hwpid_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tdata fields from bit 0: pwm_value[15:0], reached[16], warming_up[17], zero fill
    output logic [hwpid_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [hwpid_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hwpid_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [31:0] gain_p_reg;
    logic [31:0] gain_i_reg;
    logic [31:0] gain_d_reg;
    logic [15:0] int_limit_reg;
    logic [15:0] out_limit_reg;
    logic [15:0] pwm_fs_reg;
    logic [7:0]  target_reg;
    logic [7:0]  max_target_reg;

    // Controller state.
    logic                                regulating_reg;
    logic                                reached_reg;
    logic signed [hwpid_pkg::ERR_W-1:0]  prev_err_reg;
    logic signed [hwpid_pkg::ACC_W-1:0]  acc_reg;
    logic [15:0]                         held_pwm_reg;

    // Pipeline registers.
    logic                                s1_valid_reg;
    hwpid_pkg::mode_t                    s1_mode_reg;
    logic signed [hwpid_pkg::ERR_W-1:0]  s1_err_reg;
    logic signed [hwpid_pkg::DERR_W-1:0] s1_derr_reg;
    logic                                s1_reached_reg;

    logic                                 s2_valid_reg;
    hwpid_pkg::mode_t                     s2_mode_reg;
    logic signed [hwpid_pkg::PTERM_W-1:0] s2_p_reg;
    logic signed [hwpid_pkg::PTERM_W-1:0] s2_i_reg;
    logic signed [hwpid_pkg::DTERM_W-1:0] s2_d_reg;
    logic                                 s2_reached_reg;

    logic                              s3_valid_reg;
    hwpid_pkg::mode_t                  s3_mode_reg;
    logic signed [hwpid_pkg::PD_W-1:0] s3_pd_reg;
    logic                              s3_reached_reg;

    logic out_valid_reg;
    logic out_reached_reg;
    logic out_warming_reg;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    assign rdy4     = !out_valid_reg || m_tready;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign s_tready = rdy1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= hwpid_pkg::RST_GAIN_P;
            gain_i_reg     <= hwpid_pkg::RST_GAIN_I;
            gain_d_reg     <= hwpid_pkg::RST_GAIN_D;
            int_limit_reg  <= hwpid_pkg::RST_INT_LIMIT;
            out_limit_reg  <= hwpid_pkg::RST_OUT_LIMIT;
            pwm_fs_reg     <= hwpid_pkg::RST_PWM_FS;
            target_reg     <= hwpid_pkg::RST_TARGET;
            max_target_reg <= hwpid_pkg::RST_MAX_TARGET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hwpid_pkg::REG_GAIN_P:     gain_p_reg     <= cfg_data;
                hwpid_pkg::REG_GAIN_I:     gain_i_reg     <= cfg_data;
                hwpid_pkg::REG_GAIN_D:     gain_d_reg     <= cfg_data;
                hwpid_pkg::REG_INT_LIMIT:  int_limit_reg  <= cfg_data[15:0];
                hwpid_pkg::REG_OUT_LIMIT:  out_limit_reg  <= cfg_data[15:0];
                hwpid_pkg::REG_PWM_FS:     pwm_fs_reg     <= cfg_data[15:0];
                hwpid_pkg::REG_TARGET:     target_reg     <= cfg_data[7:0];
                hwpid_pkg::REG_MAX_TARGET: max_target_reg <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    // ---------------- Stage 1: target, error and mode ----------------
    logic signed [7:0]                   tgt;
    logic signed [15:0]                  meas;
    logic signed [15:0]                  tgt_q;
    logic signed [18:0]                  warm_lhs;
    logic signed [18:0]                  warm_rhs;
    logic                                warm_drive;
    logic signed [hwpid_pkg::ERR_W-1:0]  err;
    logic signed [hwpid_pkg::DERR_W-1:0] derr;
    hwpid_pkg::mode_t                    mode;
    logic                                reached_next;

    always_comb
    begin
        meas  = s_tdata[15:0];
        tgt   = ($signed(target_reg) > $signed(max_target_reg)) ? max_target_reg : target_reg;
        tgt_q = {tgt, 8'b0};
        // Four times the target against five times the sample is the exact 0.8 test.
        warm_lhs   = {tgt[7], tgt, 10'b0};
        warm_rhs   = {meas[15], meas, 2'b0} + {{3{meas[15]}}, meas};
        warm_drive = warm_lhs > warm_rhs;
        err  = {{2{tgt[7]}}, tgt, 8'b0} - {{2{meas[15]}}, meas};
        derr = {err[hwpid_pkg::ERR_W-1], err} - {prev_err_reg[hwpid_pkg::ERR_W-1], prev_err_reg};
        if (regulating_reg)
            mode = hwpid_pkg::MODE_REG;
        else if (warm_drive)
            mode = hwpid_pkg::MODE_WARM;
        else
            mode = hwpid_pkg::MODE_SWITCH;
        reached_next = reached_reg || (regulating_reg && (meas >= tgt_q));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            regulating_reg <= 1'b0;
            reached_reg    <= 1'b0;
            prev_err_reg   <= '0;
        end
        else if (rdy1)
        begin
            s1_valid_reg <= s_tvalid;
            if (s_tvalid)
            begin
                reached_reg <= reached_next;
                if (regulating_reg)
                    prev_err_reg <= err;
                else if (!warm_drive)
                    regulating_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
        begin
            s1_mode_reg    <= mode;
            s1_err_reg     <= err;
            s1_derr_reg    <= derr;
            s1_reached_reg <= reached_next;
        end
    end

    // ---------------- Stage 2: gain multiplies ----------------
    logic signed [32:0]                   kp_s;
    logic signed [32:0]                   ki_s;
    logic signed [32:0]                   kd_s;
    logic signed [hwpid_pkg::PPROD_W-1:0] p_prod;
    logic signed [hwpid_pkg::PPROD_W-1:0] i_prod;
    logic signed [hwpid_pkg::DPROD_W-1:0] d_prod;

    always_comb
    begin
        kp_s   = {1'b0, gain_p_reg};
        ki_s   = {1'b0, gain_i_reg};
        kd_s   = {1'b0, gain_d_reg};
        p_prod = kp_s * s1_err_reg;
        i_prod = ki_s * s1_err_reg;
        d_prod = kd_s * s1_derr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (rdy2)
            s2_valid_reg <= s1_valid_reg;
    end

    // Dropping the low eight bits of a two's-complement product rounds toward minus infinity.
    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_valid_reg)
        begin
            s2_mode_reg    <= s1_mode_reg;
            s2_p_reg       <= p_prod[hwpid_pkg::PPROD_W-1:8];
            s2_i_reg       <= i_prod[hwpid_pkg::PPROD_W-1:8];
            s2_d_reg       <= d_prod[hwpid_pkg::DPROD_W-1:8];
            s2_reached_reg <= s1_reached_reg;
        end
    end

    // ---------------- Stage 3: integral update ----------------
    logic signed [hwpid_pkg::ACCSUM_W-1:0] acc_sum;
    logic signed [hwpid_pkg::ACCSUM_W-1:0] acc_lim;
    logic signed [hwpid_pkg::ACCSUM_W-1:0] acc_clamped;
    logic signed [hwpid_pkg::PD_W-1:0]     pd_sum;

    always_comb
    begin
        acc_sum = {{(hwpid_pkg::ACCSUM_W - hwpid_pkg::ACC_W){acc_reg[hwpid_pkg::ACC_W-1]}}, acc_reg}
                + {s2_i_reg[hwpid_pkg::PTERM_W-1], s2_i_reg};
        acc_lim = {12'b0, int_limit_reg, 16'b0};
        if (acc_sum < -acc_lim)
            acc_clamped = -acc_lim;
        else if (acc_sum > acc_lim)
            acc_clamped = acc_lim;
        else
            acc_clamped = acc_sum;
        pd_sum = {{2{s2_p_reg[hwpid_pkg::PTERM_W-1]}}, s2_p_reg}
               + {s2_d_reg[hwpid_pkg::DTERM_W-1], s2_d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else if (rdy3)
        begin
            s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                case (s2_mode_reg)
                    hwpid_pkg::MODE_REG:    acc_reg <= acc_clamped[hwpid_pkg::ACC_W-1:0];
                    // Seed the integral with half of full scale.
                    hwpid_pkg::MODE_SWITCH: acc_reg <= {2'b0, pwm_fs_reg, 15'b0};
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_valid_reg)
        begin
            s3_mode_reg    <= s2_mode_reg;
            s3_pd_reg      <= pd_sum;
            s3_reached_reg <= s2_reached_reg;
        end
    end

    // ---------------- Stage 4: sum, clamp and result word ----------------
    logic signed [hwpid_pkg::SUM_W-1:0] pid_sum;
    logic signed [hwpid_pkg::SUM_W-1:0] out_lim;
    logic signed [hwpid_pkg::SUM_W-1:0] sum_clamped;
    logic [15:0]                        pid_pwm;
    logic [15:0]                        warm_pwm;

    always_comb
    begin
        pid_sum = {s3_pd_reg[hwpid_pkg::PD_W-1], s3_pd_reg}
                + {{(hwpid_pkg::SUM_W - hwpid_pkg::ACC_W){acc_reg[hwpid_pkg::ACC_W-1]}}, acc_reg};
        out_lim = {14'b0, out_limit_reg, 16'b0};
        if (pid_sum < -out_lim)
            sum_clamped = -out_lim;
        else if (pid_sum > out_lim)
            sum_clamped = out_lim;
        else
            sum_clamped = pid_sum;
        pid_pwm  = sum_clamped[hwpid_pkg::SUM_W-1] ? 16'd0 : sum_clamped[31:16];
        // A zero full scale drives zero rather than wrapping.
        warm_pwm = (pwm_fs_reg == 16'd0) ? 16'd0 : pwm_fs_reg - 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            held_pwm_reg    <= '0;
            out_reached_reg <= 1'b0;
            out_warming_reg <= 1'b0;
        end
        else if (rdy4)
        begin
            out_valid_reg <= s3_valid_reg;
            if (s3_valid_reg)
            begin
                out_reached_reg <= s3_reached_reg;
                out_warming_reg <= (s3_mode_reg == hwpid_pkg::MODE_WARM);
                case (s3_mode_reg)
                    hwpid_pkg::MODE_REG:  held_pwm_reg <= pid_pwm;
                    hwpid_pkg::MODE_WARM: held_pwm_reg <= warm_pwm;
                    // The switching word repeats the held value.
                    default:              ;
                endcase
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_warming_reg, out_reached_reg, held_pwm_reg};

endmodule

`default_nettype wire

FILE: src/hwpid_checker.sv
// Port-level checker for the heater warm-up PID controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hwpid_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [hwpid_pkg::OUT_DATA_W-1:0]   m_tdata
);

    logic       seen_reg_mode_reg;
    logic       seen_reached_reg;
    logic [2:0] inflight_reg;
    logic       in_word;
    logic       out_word;

    assign in_word  = s_tvalid && s_tready;
    assign out_word = m_tvalid && m_tready;

    // These track only what earlier delivered words showed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg_mode_reg <= 1'b0;
            seen_reached_reg  <= 1'b0;
        end
        else if (out_word)
        begin
            if (!m_tdata[17])
                seen_reg_mode_reg <= 1'b1;
            if (m_tdata[16])
                seen_reached_reg <= 1'b1;
        end
    end

    // Samples accepted but not yet delivered; the four stages hold at most four.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_reg + {2'b0, in_word} - {2'b0, out_word};
    end

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Once regulation starts, warm-up never comes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && seen_reg_mode_reg |-> !m_tdata[17])
        else $error("warm-up flag returned after regulation");

    // The reached flag is sticky.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && seen_reached_reg |-> m_tdata[16])
        else $error("reached flag cleared");

    // The reached flag is never set in a warm-up word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17] |-> !m_tdata[16])
        else $error("reached flag set during warm-up");

    // No result word appears without a sample still owed.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != '0)
        else $error("result word without a sample");

endmodule

bind heater_warmup_pid_controller_unit hwpid_checker u_hwpid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

FILE: tb/sv/tb_heater_warmup_pid_controller_unit.sv
// Self-checking testbench of the heater warm-up PID controller: directed table, then random phases.
`timescale 1ns / 1ps

module tb_heater_warmup_pid_controller_unit;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 144;
    localparam int MAX_GAP       = 17;
    localparam int LONG_HOLD     = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;

    typedef struct packed {
        logic        warming;
        logic        reached;
        logic [15:0] pwm;
    } heater_word_t;

    typedef struct {
        bit                                idx_unused_pad;
        bit                                is_cfg;
        logic [hwpid_pkg::CFG_INDEX_W-1:0] idx;
        logic [31:0]                       value;
        logic [15:0]                       temp;
        bit                                typed;
        heater_word_t                      want;
    } plan_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [hwpid_pkg::IN_DATA_W-1:0]     s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [hwpid_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [hwpid_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [hwpid_pkg::CFG_DATA_W-1:0]    cfg_data;

    // Register copies kept by the predictor.
    logic [31:0]        kp_q16;
    logic [31:0]        ki_q16;
    logic [31:0]        kd_q16;
    logic [15:0]        int_lim;
    logic [15:0]        out_lim;
    logic [15:0]        pwm_fs;
    logic signed [7:0]  tgt_deg;
    logic signed [7:0]  tgt_max_deg;

    // Controller state kept by the predictor.
    bit          reg_mode;
    longint      integral_q16;
    longint      prev_err_q8;
    logic [15:0] held_pwm_q;
    bit          reached_q;

    heater_word_t words_due[$];
    heater_word_t due_word;
    plan_row_t    plan[$];
    int           errors;
    int           cycle_count;
    bit           src_gaps_on;
    bit           snk_gaps_on;
    bit           hold_pending;

    heater_warmup_pid_controller_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Effective target in Q8.8; only the upper clamp applies.
    function automatic int target_q8();
        logic signed [7:0] t;
        t = (tgt_deg > tgt_max_deg) ? tgt_max_deg : tgt_deg;
        return int'(t) * 256;
    endfunction

    function automatic heater_word_t heater_pid_step(input logic [15:0] raw);
        int           meas;
        longint       tq;
        longint       err;
        longint       kp;
        longint       ki;
        longint       kd;
        longint       lim;
        longint       p;
        longint       d;
        longint       sum;
        heater_word_t w;
        meas = $signed(raw);
        tq = target_q8();
        if (reg_mode)
        begin
            kp = kp_q16;
            ki = ki_q16;
            kd = kd_q16;
            err = tq - meas;
            p = (kp * err) >>> 8;
            d = (kd * (err - prev_err_q8)) >>> 8;
            integral_q16 = integral_q16 + ((ki * err) >>> 8);
            lim = int_lim;
            lim = lim * 65536;
            if (integral_q16 > lim)
                integral_q16 = lim;
            else if (integral_q16 < -lim)
                integral_q16 = -lim;
            sum = p + integral_q16 + d;
            lim = out_lim;
            lim = lim * 65536;
            if (sum > lim)
                sum = lim;
            else if (sum < -lim)
                sum = -lim;
            if (sum < 0)
                sum = 0;
            held_pwm_q = 16'(sum >>> 16);
            if (meas >= tq)
                reached_q = 1'b1;
            prev_err_q8 = err;
        end
        else if (tq * 4 > meas * 5)
        begin
            held_pwm_q = (pwm_fs == 16'd0) ? 16'd0 : pwm_fs - 16'd1;
        end
        else
        begin
            // Switching tick: seed the integral at half scale and keep the PWM.
            integral_q16 = longint'(pwm_fs) * 32768;
            reg_mode = 1'b1;
        end
        w.pwm = held_pwm_q;
        w.reached = reached_q;
        w.warming = ~reg_mode;
        return w;
    endfunction

    function automatic plan_row_t cfg_row(input logic [hwpid_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [31:0] value);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.value = value;
        return r;
    endfunction

    function automatic plan_row_t smp(input logic [15:0] temp);
        plan_row_t r;
        r = '{default: '0};
        r.temp = temp;
        return r;
    endfunction

    function automatic plan_row_t smp_chk(input logic [15:0] temp, input logic [15:0] pwm,
                                          input logic reached, input logic warming);
        plan_row_t r;
        r = smp(temp);
        r.typed = 1'b1;
        r.want.pwm = pwm;
        r.want.reached = reached;
        r.want.warming = warming;
        return r;
    endfunction

    task automatic drive_sample(input logic [15:0] temp, input bit typed,
                                input heater_word_t want);
        int           gap;
        heater_word_t predicted;
        gap = src_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= temp;
        do @(posedge clk); while (!s_tready);
        predicted = heater_pid_step(temp);
        words_due.push_back(typed ? want : predicted);
    endtask

    // Stops the sample stream and waits until every word in flight is out.
    task automatic settle_pipeline();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hwpid_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            hwpid_pkg::REG_GAIN_P:     kp_q16 = value;
            hwpid_pkg::REG_GAIN_I:     ki_q16 = value;
            hwpid_pkg::REG_GAIN_D:     kd_q16 = value;
            hwpid_pkg::REG_INT_LIMIT:  int_lim = value[15:0];
            hwpid_pkg::REG_OUT_LIMIT:  out_lim = value[15:0];
            hwpid_pkg::REG_PWM_FS:     pwm_fs = value[15:0];
            hwpid_pkg::REG_TARGET:     tgt_deg = value[7:0];
            hwpid_pkg::REG_MAX_TARGET: tgt_max_deg = value[7:0];
            default:                   ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h0800_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd65535;
            2, 3:    return $urandom_range(0, 65535);
            default: return $urandom_range(1000, 6000);
        endcase
    endfunction

    // Mostly samples around the target so the loop regulates, some anywhere.
    function automatic logic [15:0] pick_temp();
        int t;
        int v;
        int span;
        t = target_q8();
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(0, 65535) - 32768;
            2:       v = t;
            default:
            begin
                span = 1 << $urandom_range(2, 12);
                v = t + $urandom_range(0, 2 * span) - span;
            end
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (words_due.size() == 0)
            begin
                $error("result word with no sample pending: %h", m_tdata);
                errors++;
            end
            else
            begin
                due_word = words_due.pop_front();
                if (m_tdata[15:0] !== due_word.pwm)
                begin
                    $error("pwm_value expected %0d got %0d", due_word.pwm, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[16] !== due_word.reached)
                begin
                    $error("reached expected %0d got %0d", due_word.reached, m_tdata[16]);
                    errors++;
                end
                if (m_tdata[17] !== due_word.warming)
                begin
                    $error("warming_up expected %0d got %0d", due_word.warming, m_tdata[17]);
                    errors++;
                end
            end
        end
    end

    // Receiver: a random hold-off per word when gaps are on, or one long one when asked.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = hold_pending ? LONG_HOLD : (snk_gaps_on ? $urandom_range(0, MAX_GAP) : 0);
            hold_pending = 1'b0;
            @(negedge clk);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        hold_pending = 1'b0;
        kp_q16 = hwpid_pkg::RST_GAIN_P;
        ki_q16 = hwpid_pkg::RST_GAIN_I;
        kd_q16 = hwpid_pkg::RST_GAIN_D;
        int_lim = hwpid_pkg::RST_INT_LIMIT;
        out_lim = hwpid_pkg::RST_OUT_LIMIT;
        pwm_fs = hwpid_pkg::RST_PWM_FS;
        tgt_deg = hwpid_pkg::RST_TARGET;
        tgt_max_deg = hwpid_pkg::RST_MAX_TARGET;
        reg_mode = 1'b0;
        integral_q16 = 0;
        prev_err_q8 = 0;
        held_pwm_q = '0;
        reached_q = 1'b0;

        // Warm-up first: the block never returns to it once regulating.
        plan.push_back(smp_chk(16'h8000, 16'd4999, 1'b0, 1'b1));
        plan.push_back(cfg_row(hwpid_pkg::REG_TARGET, 32'd40));
        plan.push_back(smp_chk(16'd8191, 16'd4999, 1'b0, 1'b1));
        plan.push_back(cfg_row(hwpid_pkg::REG_PWM_FS, 32'd0));
        plan.push_back(smp_chk(16'd0, 16'd0, 1'b0, 1'b1));
        plan.push_back(cfg_row(hwpid_pkg::REG_PWM_FS, 32'd65535));
        plan.push_back(smp_chk(16'hFFFF, 16'd65534, 1'b0, 1'b1));
        // Requested target above the maximum is clamped to 45 degrees.
        plan.push_back(cfg_row(hwpid_pkg::REG_MAX_TARGET, 32'd45));
        plan.push_back(cfg_row(hwpid_pkg::REG_TARGET, 32'd127));
        plan.push_back(smp_chk(16'd9215, 16'd65534, 1'b0, 1'b1));
        plan.push_back(smp_chk(16'd9216, 16'd65534, 1'b0, 1'b0));
        plan.push_back(smp(16'd9216));
        plan.push_back(cfg_row(hwpid_pkg::REG_OUT_LIMIT, 32'd0));
        plan.push_back(smp_chk(16'h8000, 16'd0, 1'b0, 1'b0));
        plan.push_back(smp_chk(16'h7FFF, 16'd0, 1'b1, 1'b0));
        plan.push_back(cfg_row(hwpid_pkg::REG_OUT_LIMIT, 32'd65535));
        plan.push_back(cfg_row(hwpid_pkg::REG_INT_LIMIT, 32'd65535));
        plan.push_back(cfg_row(hwpid_pkg::REG_GAIN_P, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(hwpid_pkg::REG_GAIN_I, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(hwpid_pkg::REG_GAIN_D, 32'hFFFF_FFFF));
        plan.push_back(smp(16'h8000));
        plan.push_back(smp(16'h7FFF));
        plan.push_back(smp(16'h8000));
        plan.push_back(smp(16'd0));
        plan.push_back(cfg_row(hwpid_pkg::REG_INT_LIMIT, 32'd0));
        plan.push_back(smp(16'h8000));
        // Lowest target with the highest maximum: no lower clamp exists.
        plan.push_back(cfg_row(hwpid_pkg::REG_TARGET, 32'h80));
        plan.push_back(cfg_row(hwpid_pkg::REG_MAX_TARGET, 32'd127));
        plan.push_back(smp(16'h8000));
        plan.push_back(smp(16'h7FFF));
        plan.push_back(cfg_row(hwpid_pkg::REG_GAIN_P, 32'd0));
        plan.push_back(cfg_row(hwpid_pkg::REG_GAIN_I, 32'd0));
        plan.push_back(cfg_row(hwpid_pkg::REG_GAIN_D, 32'd0));
        plan.push_back(smp(16'd0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle_pipeline();
                write_reg(plan[i].idx, plan[i].value);
            end
            else
            begin
                drive_sample(plan[i].temp, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_pipeline();
            write_reg(hwpid_pkg::REG_GAIN_P, rand_gain());
            write_reg(hwpid_pkg::REG_GAIN_I, rand_gain());
            write_reg(hwpid_pkg::REG_GAIN_D, rand_gain());
            write_reg(hwpid_pkg::REG_INT_LIMIT, rand_limit());
            write_reg(hwpid_pkg::REG_OUT_LIMIT, rand_limit());
            write_reg(hwpid_pkg::REG_PWM_FS, $urandom_range(1, 65535));
            write_reg(hwpid_pkg::REG_TARGET, $urandom_range(0, 255));
            write_reg(hwpid_pkg::REG_MAX_TARGET, $urandom_range(0, 255));
            src_gaps_on = ($urandom_range(0, 3) != 0);
            snk_gaps_on = ($urandom_range(0, 3) != 0);
            // One phase streams flat out into a stalled receiver.
            if (ph == 1)
            begin
                src_gaps_on = 1'b0;
                snk_gaps_on = 1'b0;
                hold_pending = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                drive_sample(pick_temp(), 1'b0, '0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
